@@ rtl/frame_difference_threshold_top_defines.svh @@
// Assertion macros shared by the frame difference blocks.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FRAME_DIFFERENCE_THRESHOLD_TOP_DEFINES_SVH
`define FRAME_DIFFERENCE_THRESHOLD_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame difference check failed");

// The consequent must hold in the cycle after the antecedent.
`define FDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame difference check failed");

`endif

@@ rtl/fdt_pkg.sv @@
package fdt_pkg;

    localparam int BYTES      = 8;
    localparam int BYTE_W     = 8;
    localparam int PAIR_W     = BYTES * BYTE_W;
    // Largest sum over eight bytes is 8 * 255 = 2040.
    localparam int SUM_W      = 11;
    localparam int TOTAL_W    = SUM_W + 1;
    localparam int RECIP_W    = 30;
    localparam int PROD_W     = TOTAL_W + RECIP_W;
    localparam int GRAY_LSB   = 32;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE = 2'd1;

    localparam logic MODE_TWO_FRAME   = 1'b0;
    localparam logic MODE_THREE_FRAME = 1'b1;

    localparam logic [RECIP_W-1:0] TWO_FRAME_RECIP   = 30'd715827883;
    localparam logic [RECIP_W-1:0] THREE_FRAME_RECIP = 30'd357913941;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic [SUM_W-1:0] sum_a;
        logic [SUM_W-1:0] sum_b;
    } sums_t;

endpackage

@@ rtl/frame_difference_threshold_top.sv @@
// Frame difference threshold: takes one item (the same two BGRA pixels from the
// current, previous and next frames) per clock while in_stall is low and returns
// one result item per item, in order.
// The four register stages are byte differences, sums, threshold test and the
// reciprocal multiply; the last stage is the output register, so a new item is
// accepted while a finished result waits. A stall on the output backs up through
// the stages and reaches in_stall only once every stage holds an item.
// Registers: index 0 is threshold (8 bits, reset 0), index 1 is frame_mode
// (bit 0, reset 1 for three-frame mode); write them only while no item is in flight.
module frame_difference_threshold_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fdt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fdt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [fdt_pkg::PAIR_W-1:0]       current_pair,
    input  logic [fdt_pkg::PAIR_W-1:0]       previous_pair,
    input  logic [fdt_pkg::PAIR_W-1:0]       next_pair,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fdt_pkg::PAIR_W-1:0]       result_pair
);
    import fdt_pkg::*;

    logic [BYTE_W-1:0] threshold_reg;
    logic              frame_mode_reg;
    logic              sums_valid;
    logic              sums_stall;
    sums_t             sums;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= '0;
            frame_mode_reg <= MODE_THREE_FRAME;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_THRESHOLD:  threshold_reg  <= cfg_data[BYTE_W-1:0];
                REG_FRAME_MODE: frame_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    fdt_sad u_sad (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .current_pair  (current_pair),
        .previous_pair (previous_pair),
        .next_pair     (next_pair),
        .sums_valid    (sums_valid),
        .sums_stall    (sums_stall),
        .sums          (sums)
    );

    fdt_gray u_gray (
        .clk         (clk),
        .rst_n       (rst_n),
        .sums_valid  (sums_valid),
        .sums_stall  (sums_stall),
        .sums        (sums),
        .threshold   (threshold_reg),
        .frame_mode  (frame_mode_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_pair (result_pair)
    );

endmodule

@@ rtl/fdt_sad.sv @@
`include "frame_difference_threshold_top_defines.svh"

module fdt_sad (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [fdt_pkg::PAIR_W-1:0]  current_pair,
    input  logic [fdt_pkg::PAIR_W-1:0]  previous_pair,
    input  logic [fdt_pkg::PAIR_W-1:0]  next_pair,
    output logic                        sums_valid,
    input  logic                        sums_stall,
    output fdt_pkg::sums_t              sums
);
    import fdt_pkg::*;

    logic [BYTE_W-1:0] diff_a_reg [BYTES];
    logic [BYTE_W-1:0] diff_b_reg [BYTES];
    logic [BYTE_W-1:0] diff_a_next [BYTES];
    logic [BYTE_W-1:0] diff_b_next [BYTES];
    logic              diff_valid_reg;
    sums_t             sums_reg;
    sums_t             sums_next;
    logic              sums_valid_reg;
    logic              diff_ready;
    logic              sums_ready;

    assign sums_ready = !sums_valid_reg || !sums_stall;
    assign diff_ready = !diff_valid_reg || sums_ready;
    assign in_stall   = !diff_ready;
    assign sums_valid = sums_valid_reg;
    assign sums       = sums_reg;

    // Stage one: per-byte absolute differences against both neighbor frames.
    always_comb
    begin
        for (int i = 0; i < BYTES; i++)
        begin
            logic [BYTE_W-1:0] cur;
            logic [BYTE_W-1:0] prv;
            logic [BYTE_W-1:0] nxt;
            cur = current_pair[i*BYTE_W +: BYTE_W];
            prv = previous_pair[i*BYTE_W +: BYTE_W];
            nxt = next_pair[i*BYTE_W +: BYTE_W];
            diff_a_next[i] = (cur > prv) ? (cur - prv) : (prv - cur);
            diff_b_next[i] = (cur > nxt) ? (cur - nxt) : (nxt - cur);
        end
    end

    // Stage two: add up the eight differences of each side.
    always_comb
    begin
        sums_next = '0;
        for (int i = 0; i < BYTES; i++)
        begin
            sums_next.sum_a = sums_next.sum_a + SUM_W'(diff_a_reg[i]);
            sums_next.sum_b = sums_next.sum_b + SUM_W'(diff_b_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            sums_valid_reg <= 1'b0;
        end
        else
        begin
            if (diff_ready)
            begin
                diff_valid_reg <= in_valid;
            end
            if (sums_ready)
            begin
                sums_valid_reg <= diff_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (diff_ready && in_valid)
        begin
            diff_a_reg <= diff_a_next;
            diff_b_reg <= diff_b_next;
        end
        if (sums_ready && diff_valid_reg)
        begin
            sums_reg <= sums_next;
        end
    end

    `FDT_ASSERT_SAME(sums_in_range_a, sums_valid_reg, sums_reg.sum_a <= SUM_W'(2040))
    `FDT_ASSERT_NEXT(diff_moves_on, diff_valid_reg && sums_ready, sums_valid_reg)

endmodule

@@ rtl/fdt_gray.sv @@
`include "frame_difference_threshold_top_defines.svh"

module fdt_gray (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sums_valid,
    output logic                           sums_stall,
    input  fdt_pkg::sums_t                 sums,
    input  logic [fdt_pkg::BYTE_W-1:0]     threshold,
    input  logic                           frame_mode,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fdt_pkg::PAIR_W-1:0]     result_pair
);
    import fdt_pkg::*;

    logic [SUM_W-1:0]   limit;
    logic               pass_a;
    logic               pass_b;
    logic [TOTAL_W-1:0] operand_reg;
    logic [TOTAL_W-1:0] operand_next;
    logic               mode_reg;
    logic               operand_valid_reg;
    logic               operand_ready;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  product;
    logic [BYTE_W-1:0]  gray;
    logic [PAIR_W-1:0]  result_reg;
    logic [PAIR_W-1:0]  result_next;
    logic               result_valid_reg;
    logic               result_ready;

    assign result_ready  = !result_valid_reg || !out_stall;
    assign operand_ready = !operand_valid_reg || result_ready;
    assign sums_stall    = !operand_ready;
    assign out_valid     = result_valid_reg;
    assign result_pair   = result_reg;

    // Stage three: threshold test. A pair that fails gets a zero operand,
    // so the multiply below yields gray 0 without a separate select.
    always_comb
    begin
        limit  = SUM_W'({threshold, 2'b00}) + SUM_W'({threshold, 1'b0});
        pass_a = sums.sum_a > limit;
        pass_b = sums.sum_b > limit;
        operand_next = '0;
        if (frame_mode == MODE_TWO_FRAME)
        begin
            if (pass_a)
            begin
                operand_next = TOTAL_W'(sums.sum_a);
            end
        end
        else
        begin
            if (pass_a && pass_b)
            begin
                operand_next = TOTAL_W'(sums.sum_a) + TOTAL_W'(sums.sum_b);
            end
        end
    end

    // Stage four: reciprocal multiply; only the low byte of the quotient is kept.
    always_comb
    begin
        recip   = (mode_reg == MODE_THREE_FRAME) ? THREE_FRAME_RECIP : TWO_FRAME_RECIP;
        product = PROD_W'(operand_reg) * PROD_W'(recip);
        gray    = product[GRAY_LSB +: BYTE_W];
        result_next = {ALPHA_OPAQUE, gray, gray, gray, ALPHA_OPAQUE, gray, gray, gray};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_valid_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (operand_ready)
            begin
                operand_valid_reg <= sums_valid;
            end
            if (result_ready)
            begin
                result_valid_reg <= operand_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (operand_ready && sums_valid)
        begin
            operand_reg <= operand_next;
            mode_reg    <= frame_mode;
        end
        if (result_ready && operand_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    `FDT_ASSERT_SAME(alpha_low_opaque, result_valid_reg, result_reg[31:24] == ALPHA_OPAQUE)
    `FDT_ASSERT_SAME(alpha_high_opaque, result_valid_reg, result_reg[63:56] == ALPHA_OPAQUE)
    `FDT_ASSERT_SAME(fail_gives_black, operand_valid_reg && operand_reg == '0, gray == '0)

endmodule
